/* hw/rtl/ncdf_pkg.sv */
package ncdf_pkg;

  localparam int FRAC_BITS_DEF = 16;

  localparam int DATA_W = 32;
  localparam int MAG_W  = DATA_W + 1;
  localparam int E_W    = 6;
  localparam int ROOT_W = 31;
  localparam int Z_FRAC = 16;
  localparam int ZQ_W   = Z_FRAC + 3;
  localparam int ZNUM_W = 80;
  localparam int DEN_W  = 32;
  localparam int KNUM_W = 61;
  localparam int K_W    = 31;
  localparam int G_W    = 29;
  localparam int PROB_W = 17;

  localparam int Q_FRAC = 30;
  localparam int Q_W    = Q_FRAC + 1;
  localparam logic [Q_W-1:0] QONE = Q_W'(1) << Q_FRAC;

  localparam logic [27:0]    C_K          = 28'd248723596;
  localparam logic [30:0]    C_LOG2E      = 31'd1549082005;
  localparam logic [29:0]    C_LN2        = 30'd744261118;
  localparam logic [G_W-1:0] C_INVSQRT2PI = 29'd428361012;

  typedef struct packed {
    logic neg;
    logic sat;
    logic bad;
  } ncdf_flags_t;

  localparam int FLAGS_W = $bits(ncdf_flags_t);

endpackage

/* hw/rtl/ncdf_sqrt.sv */
module ncdf_sqrt #(
  parameter int FRAC_BITS = ncdf_pkg::FRAC_BITS_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [ncdf_pkg::DATA_W-1:0]  sample,
  input  logic signed [ncdf_pkg::DATA_W-1:0]  mean,
  input  logic [ncdf_pkg::DATA_W-1:0]         variance,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [ncdf_pkg::MAG_W-1:0]          mag,
  output logic [ncdf_pkg::E_W-1:0]            e,
  output logic [ncdf_pkg::ROOT_W-1:0]         root,
  output ncdf_pkg::ncdf_flags_t               status
);
  import ncdf_pkg::*;

  localparam int NORM_N = 5;
  localparam int NS     = 1 + NORM_N + ROOT_W;
  localparam int X_W    = 62;
  localparam int RES_W  = 63;

  typedef struct packed {
    logic [MAG_W-1:0] mag;
    ncdf_flags_t      flags;
    logic [E_W-1:0]   e;
    logic [X_W-1:0]   x;
    logic [RES_W-1:0] res;
  } sq_stage_t;

  function automatic sq_stage_t step(sq_stage_t a, int j);
    sq_stage_t        b;
    int               sh;
    logic [RES_W-1:0] bitv;
    logic [RES_W-1:0] trial;
    b = a;
    if (j <= NORM_N) begin
      sh = 64 >> j;
      if ((a.x >> (X_W - sh)) == '0) begin
        b.x = a.x << sh;
        b.e = a.e + E_W'(sh);
      end
    end else begin
      bitv  = RES_W'(1) << (X_W - 2 - 2 * (j - NORM_N - 1));
      trial = a.res + bitv;
      if (RES_W'(a.x) >= trial) begin
        b.x   = a.x - X_W'(trial);
        b.res = (a.res >> 1) + bitv;
      end else begin
        b.res = a.res >> 1;
      end
    end
    return b;
  endfunction

  sq_stage_t        st [NS];
  sq_stage_t        ent;
  logic [NS-1:0]    v;
  logic [NS-1:0]    go;
  logic [MAG_W-1:0] diff;

  always_comb begin
    diff = {sample[DATA_W-1], sample} - {mean[DATA_W-1], mean};
    ent           = '0;
    ent.flags.neg = diff[MAG_W-1];
    ent.flags.bad = (variance == '0);
    ent.mag       = diff[MAG_W-1] ? -diff : diff;
    ent.x         = X_W'(variance) << FRAC_BITS;
  end

  always_comb begin
    go[NS-1] = !v[NS-1] || !out_stall;
    for (int j = NS - 2; j >= 0; j--) begin
      go[j] = !v[j] || go[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) begin
        v[0] <= in_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (go[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      st[0] <= ent;
    end
    for (int j = 1; j < NS; j++) begin
      if (go[j]) begin
        st[j] <= step(st[j-1], j);
      end
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = v[NS-1];
  assign mag       = st[NS-1].mag;
  assign e         = st[NS-1].e;
  assign root      = st[NS-1].res[ROOT_W-1:0];
  assign status    = st[NS-1].flags;

  // A normalized radicand always gives a root with its top bit set.
  a_root_normalized: assert property (@(posedge clk) disable iff (rst)
    out_valid && !status.bad |-> root[ROOT_W-1])
    else $error("square root result is not normalized");

endmodule

/* hw/rtl/ncdf_div.sv */
module ncdf_div #(
  parameter int NW = 80,
  parameter int DW = 31,
  parameter int QW = 19,
  parameter int SW = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic [SW-1:0] tag,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [QW-1:0] quot,
  output logic          over,
  output logic [SW-1:0] carried
);

  localparam int NS = QW + 1;
  localparam int HW = NW - QW;
  localparam int CW = HW + DW;

  logic [NS-1:0] v;
  logic [NS-1:0] go;
  logic [NW-1:0] num0;
  logic [DW-1:0] den_s [0:QW];
  logic [SW-1:0] tag_s [0:QW];
  logic [DW-1:0] rem_s [1:QW];
  logic [QW-1:0] low_s [1:QW];
  logic [QW-1:0] q_s   [1:QW];
  logic [QW:1]   over_s;

  logic [DW-1:0] prv_rem  [1:QW];
  logic [QW-1:0] prv_low  [1:QW];
  logic [QW-1:0] prv_q    [1:QW];
  logic [QW:1]   prv_over;
  logic [DW-1:0] nrem [1:QW];
  logic [QW-1:0] nlow [1:QW];
  logic [QW-1:0] nq   [1:QW];
  logic [CW-1:0] hi_ext;
  logic [CW-1:0] den_ext;

  always_comb begin
    hi_ext      = {{DW{1'b0}}, num0[NW-1:QW]};
    den_ext     = {{HW{1'b0}}, den_s[0]};
    prv_rem[1]  = hi_ext[DW-1:0];
    prv_low[1]  = num0[QW-1:0];
    prv_q[1]    = '0;
    prv_over[1] = (hi_ext >= den_ext);
    for (int j = 2; j <= QW; j++) begin
      prv_rem[j]  = rem_s[j-1];
      prv_low[j]  = low_s[j-1];
      prv_q[j]    = q_s[j-1];
      prv_over[j] = over_s[j-1];
    end
  end

  always_comb begin
    logic [DW:0] t;
    logic        ge;
    for (int j = 1; j <= QW; j++) begin
      t       = {prv_rem[j], prv_low[j][QW-1]};
      ge      = (t >= {1'b0, den_s[j-1]});
      nrem[j] = ge ? DW'(t - {1'b0, den_s[j-1]}) : t[DW-1:0];
      nlow[j] = prv_low[j] << 1;
      nq[j]   = {prv_q[j][QW-2:0], ge};
    end
  end

  always_comb begin
    go[NS-1] = !v[NS-1] || !out_stall;
    for (int j = NS - 2; j >= 0; j--) begin
      go[j] = !v[j] || go[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) begin
        v[0] <= in_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (go[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      num0     <= num;
      den_s[0] <= den;
      tag_s[0] <= tag;
    end
    for (int j = 1; j <= QW; j++) begin
      if (go[j]) begin
        rem_s[j]  <= nrem[j];
        low_s[j]  <= nlow[j];
        q_s[j]    <= nq[j];
        over_s[j] <= prv_over[j];
        den_s[j]  <= den_s[j-1];
        tag_s[j]  <= tag_s[j-1];
      end
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = v[NS-1];
  assign quot      = q_s[QW];
  assign over      = over_s[QW];
  assign carried   = tag_s[QW];

endmodule

/* hw/rtl/ncdf_exp.sv */
module ncdf_exp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ncdf_pkg::ZQ_W-1:0]     z,
  input  ncdf_pkg::ncdf_flags_t         flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ncdf_pkg::DEN_W-1:0]    den,
  output logic [ncdf_pkg::G_W-1:0]      g,
  output ncdf_pkg::ncdf_flags_t         status
);
  import ncdf_pkg::*;

  localparam int NS    = 25;
  localparam int U_W   = 33;
  localparam int F_W   = 30;
  localparam int TERMS = 10;
  localparam int RSH   = 34;

  localparam logic [34:0] RECIP [1:TERMS] = '{
    35'd17179869184, 35'd8589934592, 35'd5726623062, 35'd4294967296, 35'd3435973837,
    35'd2863311531,  35'd2454267027, 35'd2147483648, 35'd1908874354, 35'd1717986919
  };

  typedef struct packed {
    ncdf_flags_t      flags;
    logic [DEN_W-1:0] den;
    logic [U_W-1:0]   u;
    logic [E_W-1:0]   n;
    logic [F_W-1:0]   f;
    logic [F_W-1:0]   y;
    logic [Q_W-1:0]   s;
    logic [F_W-1:0]   pm;
    logic [Q_W-1:0]   ex;
    logic [G_W-1:0]   g;
  } ex_stage_t;

  function automatic ex_stage_t step(ex_stage_t a, int j);
    ex_stage_t      b;
    logic [63:0]    t;
    logic [F_W-1:0] quo;
    int             k;
    int             dv;
    b = a;
    if (j == 1) begin
      t   = (64'(a.u) * 64'(C_LOG2E)) >> 28;
      b.n = t[F_W+E_W-1:F_W];
      b.f = t[F_W-1:0];
    end else if (j == 2) begin
      b.y = F_W'((60'(a.f) * 60'(C_LN2)) >> Q_FRAC);
      b.s = QONE;
    end else if (j < 3 + 2 * TERMS) begin
      k  = j - 3;
      dv = TERMS - k / 2;
      if (k % 2 == 0) begin
        b.pm = F_W'((61'(a.y) * 61'(a.s)) >> Q_FRAC);
      end else begin
        if (dv == 1) begin
          quo = a.pm;
        end else begin
          quo = F_W'((65'(a.pm) * 65'(RECIP[dv])) >> RSH);
        end
        b.s = QONE - Q_W'(quo);
      end
    end else if (j == 3 + 2 * TERMS) begin
      b.ex = a.s >> a.n;
    end else begin
      b.g = G_W'((60'(C_INVSQRT2PI) * 60'(a.ex)) >> Q_FRAC);
    end
    return b;
  endfunction

  ex_stage_t     st [NS];
  ex_stage_t     ent;
  logic [NS-1:0] v;
  logic [NS-1:0] go;
  logic [46:0]   kz;

  always_comb begin
    kz        = 47'(C_K) * 47'(z);
    ent       = '0;
    ent.flags = flags;
    ent.den   = DEN_W'(QONE) + DEN_W'(kz >> Z_FRAC);
    ent.u     = U_W'((38'(z) * 38'(z)) >> 5);
  end

  always_comb begin
    go[NS-1] = !v[NS-1] || !out_stall;
    for (int j = NS - 2; j >= 0; j--) begin
      go[j] = !v[j] || go[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) begin
        v[0] <= in_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (go[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      st[0] <= ent;
    end
    for (int j = 1; j < NS; j++) begin
      if (go[j]) begin
        st[j] <= step(st[j-1], j);
      end
    end
  end

  assign in_stall  = !go[0];
  assign out_valid = v[NS-1];
  assign den       = st[NS-1].den;
  assign g         = st[NS-1].g;
  assign status    = st[NS-1].flags;

endmodule

/* hw/rtl/ncdf_poly.sv */
module ncdf_poly (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ncdf_pkg::K_W-1:0]      k,
  input  logic [ncdf_pkg::G_W-1:0]      g,
  input  ncdf_pkg::ncdf_flags_t         flags,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ncdf_pkg::PROB_W-1:0]   probability,
  output logic                          bad_variance
);
  import ncdf_pkg::*;

  localparam int NS = 7;
  localparam int P_W = 36;
  localparam int PROB_SH = Q_FRAC - 16;
  localparam logic [31:0] ROUND = 32'(1) << (PROB_SH - 1);
  localparam logic [PROB_W:0] ONE_PROB = (PROB_W + 1)'(1) << 16;

  localparam logic signed [P_W-1:0] COEF [0:4] = '{
    36'sd342933307, -36'sd382857446, 36'sd1912847370, -36'sd1955558716, 36'sd1428371292
  };

  typedef struct packed {
    logic [K_W-1:0]        k;
    logic [G_W-1:0]        g;
    ncdf_flags_t           flags;
    logic signed [P_W-1:0] p;
    logic [PROB_W-1:0]     prob;
  } po_stage_t;

  function automatic logic signed [P_W-1:0] mulk(logic signed [P_W-1:0] a,
                                                 logic [K_W-1:0] kk);
    logic [P_W-1:0]     m;
    logic [P_W+K_W-1:0] prod;
    m    = a[P_W-1] ? P_W'(-a) : P_W'(a);
    prod = (P_W + K_W)'(m) * (P_W + K_W)'(kk);
    m    = P_W'(prod >> Q_FRAC);
    return a[P_W-1] ? -signed'(m) : signed'(m);
  endfunction

  function automatic po_stage_t step(po_stage_t a, int j);
    po_stage_t       b;
    logic [63:0]     prod;
    logic [Q_W-1:0]  tl;
    logic [Q_W-1:0]  vv;
    logic [PROB_W:0] pr;
    b = a;
    if (j <= 4) begin
      b.p = COEF[4-j] + mulk(a.p, a.k);
    end else if (j == 5) begin
      b.p = mulk(a.p, a.k);
    end else begin
      if (a.flags.sat || a.p <= 0) begin
        tl = '0;
      end else begin
        prod = 64'(a.g) * 64'(a.p[P_W-2:0]);
        if ((prod >> Q_FRAC) > 64'(QONE)) begin
          tl = QONE;
        end else begin
          tl = Q_W'(prod >> Q_FRAC);
        end
      end
      vv = a.flags.neg ? tl : QONE - tl;
      pr = (PROB_W + 1)'((32'(vv) + ROUND) >> PROB_SH);
      if (pr > ONE_PROB) begin
        pr = ONE_PROB;
      end
      b.prob = a.flags.bad ? '0 : pr[PROB_W-1:0];
    end
    return b;
  endfunction

  po_stage_t     st [NS];
  po_stage_t     ent;
  logic [NS-1:0] v;
  logic [NS-1:0] go;

  always_comb begin
    ent       = '0;
    ent.k     = k;
    ent.g     = g;
    ent.flags = flags;
    ent.p     = COEF[4];
  end

  always_comb begin
    go[NS-1] = !v[NS-1] || !out_stall;
    for (int j = NS - 2; j >= 0; j--) begin
      go[j] = !v[j] || go[j+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      if (go[0]) begin
        v[0] <= in_valid;
      end
      for (int j = 1; j < NS; j++) begin
        if (go[j]) begin
          v[j] <= v[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go[0]) begin
      st[0] <= ent;
    end
    for (int j = 1; j < NS; j++) begin
      if (go[j]) begin
        st[j] <= step(st[j-1], j);
      end
    end
  end

  assign in_stall     = !go[0];
  assign out_valid    = v[NS-1];
  assign probability  = st[NS-1].prob;
  assign bad_variance = st[NS-1].flags.bad;

  a_bad_gives_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bad_variance |-> probability == '0)
    else $error("zero variance result carries a nonzero probability");

  // A saturated positive score leaves no tail, so the probability is exactly one.
  a_sat_positive_one: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bad_variance && st[NS-1].flags.sat && !st[NS-1].flags.neg
    |-> probability == ONE_PROB[PROB_W-1:0])
    else $error("saturated score does not give probability one");

endmodule

/* hw/rtl/normal_cdf_approx_top.sv */
// Normal cumulative probability of (sample - mean) / sqrt(variance), Q16.16 in and
// Q1.16 out, with a zero variance flagged and answered with 0. The block is a
// 121-stage pipeline that takes one item per clock while in_stall is low; a stall
// holds only the stages that are full, so bubbles close up and input keeps
// flowing. The stages are split among the units: 37 stages for normalization and
// the square root, 20 for the standardizing divide, 25 for the exponential series,
// 32 for the reciprocal of the polynomial argument and 7 for the polynomial and
// the final rounding.
module normal_cdf_approx_top #(
  parameter int FRAC_BITS = ncdf_pkg::FRAC_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [ncdf_pkg::DATA_W-1:0] sample,
  input  logic signed [ncdf_pkg::DATA_W-1:0] mean,
  input  logic [ncdf_pkg::DATA_W-1:0]        variance,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ncdf_pkg::PROB_W-1:0]        probability,
  output logic                               bad_variance
);
  import ncdf_pkg::*;

  logic              sq_valid;
  logic              sq_stall;
  logic [MAG_W-1:0]  sq_mag;
  logic [E_W-1:0]    sq_e;
  logic [ROOT_W-1:0] sq_root;
  ncdf_flags_t       sq_status;
  logic [E_W-1:0]    zshift;
  logic [ZNUM_W-1:0] znum;

  logic              zd_valid;
  logic              zd_stall;
  logic [ZQ_W-1:0]   zq;
  logic              zover;
  logic [FLAGS_W-1:0] ztag;
  ncdf_flags_t       zflags;

  logic              ex_valid;
  logic              ex_stall;
  logic [DEN_W-1:0]  ex_den;
  logic [G_W-1:0]    ex_g;
  ncdf_flags_t       ex_status;
  logic [KNUM_W-1:0] knum;

  logic              kd_valid;
  logic              kd_stall;
  logic [K_W-1:0]    kq;
  logic              kover;
  logic [G_W+FLAGS_W-1:0] ktag;
  ncdf_flags_t       kflags;

  ncdf_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .sample(sample), .mean(mean), .variance(variance),
    .out_valid(sq_valid), .out_stall(sq_stall),
    .mag(sq_mag), .e(sq_e), .root(sq_root), .status(sq_status)
  );

  always_comb begin
    zshift = E_W'(Z_FRAC) + E_W'(sq_e[E_W-1:1]);
    znum   = ZNUM_W'(sq_mag) << zshift;
  end

  ncdf_div #(.NW(ZNUM_W), .DW(ROOT_W), .QW(ZQ_W), .SW(FLAGS_W)) u_zdiv (
    .clk(clk), .rst(rst),
    .in_valid(sq_valid), .in_stall(sq_stall),
    .num(znum), .den(sq_root), .tag(sq_status),
    .out_valid(zd_valid), .out_stall(zd_stall),
    .quot(zq), .over(zover), .carried(ztag)
  );

  always_comb begin
    zflags     = ncdf_flags_t'(ztag);
    zflags.sat = zover;
  end

  ncdf_exp u_exp (
    .clk(clk), .rst(rst),
    .in_valid(zd_valid), .in_stall(zd_stall),
    .z(zq), .flags(zflags),
    .out_valid(ex_valid), .out_stall(ex_stall),
    .den(ex_den), .g(ex_g), .status(ex_status)
  );

  assign knum = {1'b1, {(KNUM_W - 1){1'b0}}} + KNUM_W'(ex_den[DEN_W-1:1]);

  ncdf_div #(.NW(KNUM_W), .DW(DEN_W), .QW(K_W), .SW(G_W + FLAGS_W)) u_kdiv (
    .clk(clk), .rst(rst),
    .in_valid(ex_valid), .in_stall(ex_stall),
    .num(knum), .den(ex_den), .tag({ex_g, ex_status}),
    .out_valid(kd_valid), .out_stall(kd_stall),
    .quot(kq), .over(kover), .carried(ktag)
  );

  assign kflags = ncdf_flags_t'(ktag[FLAGS_W-1:0]);

  ncdf_poly u_poly (
    .clk(clk), .rst(rst),
    .in_valid(kd_valid), .in_stall(kd_stall),
    .k(kq), .g(ktag[G_W+FLAGS_W-1:FLAGS_W]), .flags(kflags),
    .out_valid(out_valid), .out_stall(out_stall),
    .probability(probability), .bad_variance(bad_variance)
  );

  // The rounded reciprocal never needs more than its quotient bits.
  a_k_in_range: assert property (@(posedge clk) disable iff (rst)
    kd_valid |-> !kover)
    else $error("reciprocal quotient overflowed");

endmodule

/* verif/tb.sv */
`timescale 1ns / 100ps

class cdf_scoreboard;
  typedef struct {
    logic [16:0] prob;
    logic        bad;
  } cdf_result_t;

  localparam longint unsigned ONE_Q30    = 64'd1 << 30;
  localparam longint unsigned Z_LIMIT    = 64'd8 << 16;
  localparam longint unsigned K_SLOPE    = 64'd248723596;
  localparam longint unsigned LOG2E_Q30  = 64'd1549082005;
  localparam longint unsigned LN2_Q30    = 64'd744261118;
  localparam longint unsigned INVRT2PI   = 64'd428361012;

  cdf_result_t pending_q[$];
  int          mismatches;

  function new();
    mismatches = 0;
  endfunction

  function int outstanding();
    return pending_q.size();
  endfunction

  function longint scale_by_k(longint a, longint unsigned k);
    longint unsigned m;
    m = (a < 0) ? longint'(-a) : a;
    m = (m * k) >> 30;
    return (a < 0) ? -longint'(m) : longint'(m);
  endfunction

  function cdf_result_t cdf_of(logic signed [31:0] smp, logic signed [31:0] mn,
                               logic [31:0] vr);
    cdf_result_t res;
    longint d, p;
    longint unsigned mag, x, rt, bitv, q, r, tail, v, prob, den, k, g;
    longint unsigned u, t, n, f, y, ser, ex, i;
    longint coef[5];
    int e, steps, j;
    bit neg, sat;
    coef[0] = 342933307;
    coef[1] = -382857446;
    coef[2] = 1912847370;
    coef[3] = -1955558716;
    coef[4] = 1428371292;
    res.prob = '0;
    res.bad = 1'b0;
    if (vr == 0) begin
      res.bad = 1'b1;
      return res;
    end
    d = longint'(smp) - longint'(mn);
    neg = d < 0;
    mag = neg ? -d : d;
    x = longint'(vr) << 16;
    e = 0;
    while (x < (64'd1 << 60)) begin
      x = x << 2;
      e += 2;
    end
    rt = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= rt + bitv) begin
        x = x - (rt + bitv);
        rt = (rt >> 1) + bitv;
      end else begin
        rt = rt >> 1;
      end
      bitv = bitv >> 2;
    end
    q = mag / rt;
    r = mag % rt;
    steps = 16 + e / 2;
    sat = 0;
    for (int s = 0; s < steps; s++) begin
      if (q >= Z_LIMIT) begin
        sat = 1;
        break;
      end
      q = q << 1;
      r = r << 1;
      if (r >= rt) begin
        r = r - rt;
        q = q | 1;
      end
    end
    if (q >= Z_LIMIT) sat = 1;
    if (sat) begin
      tail = 0;
    end else begin
      den = ONE_Q30 + ((K_SLOPE * q) >> 16);
      k = ((64'd1 << 60) + den / 2) / den;
      p = coef[4];
      for (j = 3; j >= 0; j--) p = coef[j] + scale_by_k(p, k);
      p = scale_by_k(p, k);
      u = (q * q) >> 5;
      t = (u * LOG2E_Q30) >> 28;
      n = t >> 30;
      f = t & (ONE_Q30 - 1);
      y = (f * LN2_Q30) >> 30;
      ser = ONE_Q30;
      for (i = 10; i >= 1; i--) ser = ONE_Q30 - ((y * ser) >> 30) / i;
      ex = (n >= 63) ? 0 : (ser >> n);
      g = (INVRT2PI * ex) >> 30;
      tail = (p > 0) ? (g * longint'(p)) >> 30 : 0;
      if (tail > ONE_Q30) tail = ONE_Q30;
    end
    v = neg ? tail : ONE_Q30 - tail;
    prob = (v + (64'd1 << 13)) >> 14;
    if (prob > 65536) prob = 65536;
    res.prob = prob[16:0];
    return res;
  endfunction

  function void note_transfer(logic signed [31:0] smp, logic signed [31:0] mn,
                              logic [31:0] vr);
    pending_q.push_back(cdf_of(smp, mn, vr));
  endfunction

  function void check_result(logic [16:0] prob, logic bad);
    cdf_result_t want;
    if (pending_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("Unexpected result: prob=%0d bad=%0b", prob, bad);
      return;
    end
    want = pending_q.pop_front();
    if (want.prob !== prob || want.bad !== bad) begin
      mismatches++;
      if (mismatches <= 10)
        $display("Mismatch: expected prob=%0d bad=%0b, got prob=%0d bad=%0b",
                 want.prob, want.bad, prob, bad);
    end
  endfunction
endclass

module tb;
  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic signed [31:0] sample;
  logic signed [31:0] mean;
  logic [31:0]        variance;
  logic               out_valid;
  logic               out_stall;
  logic [16:0]        probability;
  logic               bad_variance;

  cdf_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int rx_hold;
  int quiet_cycles;
  bit seen_transfer;

  normal_cdf_approx_top DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sample(sample),
    .mean(mean),
    .variance(variance),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .probability(probability),
    .bad_variance(bad_variance)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  task automatic send_item(logic signed [31:0] smp, logic signed [31:0] mn, logic [31:0] vr);
    bit taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= smp;
    mean <= mn;
    variance <= vr;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    sb.note_transfer(smp, mn, vr);
  endtask

  task automatic send_random();
    logic signed [31:0] smp, mn;
    logic [31:0] vr;
    int k;
    if ($urandom_range(0, 3) == 0) begin
      smp = $urandom;
      mn = $urandom;
      vr = $urandom >> $urandom_range(0, 31);
    end else begin
      k = $urandom_range(0, 11);
      vr = (32'd1 << (2 * k)) + $urandom_range(0, (32'd1 << (2 * k)) / 2);
      mn = $signed($urandom) >>> 2;
      smp = mn + $signed($urandom_range(0, 9 * (32'd1 << (k + 8))))
            * ($urandom_range(0, 1) ? 1 : -1);
    end
    if (vr == 0 && $urandom_range(0, 7) != 0) vr = 32'd1;
    send_item(smp, mn, vr);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
  endtask

  initial begin
    out_stall = 1'b1;
    forever begin
      @(posedge clk);
      if (rx_hold > 0) begin
        out_stall <= 1'b1;
        rx_hold--;
      end else begin
        out_stall <= ($urandom_range(0, 99) < rx_idle_pct);
      end
    end
  end

  always @(negedge clk) begin
    seen_transfer = 0;
    if (!rst && out_valid && !out_stall) begin
      sb.check_result(probability, bad_variance);
      seen_transfer = 1;
    end
    if (!rst && in_valid && !in_stall) seen_transfer = 1;
  end

  always @(posedge clk) begin
    if (rst || seen_transfer) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 5000) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin
    sb = new();
    rst = 1'b1;
    in_valid = 1'b0;
    sample = '0;
    mean = '0;
    variance = '0;
    tx_idle_pct = 19;
    rx_idle_pct = 65;
    rx_hold = 0;
    quiet_cycles = 0;
    seen_transfer = 0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(32'sd5, -32'sd9, 32'd0);
    send_item(32'sh7FFFFFFF, 32'sh80000000, 32'd0);
    send_item(32'sd0, 32'sd0, 32'd65536);
    send_item(32'sh12345678, 32'sh12345678, 32'hFFFFFFFF);
    send_item(32'sh7FFFFFFF, 32'sh80000000, 32'd1);
    send_item(32'sh80000000, 32'sh7FFFFFFF, 32'd1);
    send_item(32'sh7FFFFFFF, 32'sh80000000, 32'hFFFFFFFF);
    send_item(32'sh80000000, 32'sh7FFFFFFF, 32'hFFFFFFFF);
    send_item(32'sd65536, 32'sd0, 32'd65536);
    send_item(-32'sd65536, 32'sd0, 32'd65536);
    send_item(32'sd196608, 32'sd0, 32'd65536);
    send_item(-32'sd196608, 32'sd0, 32'd65536);
    send_item(32'sd524288, 32'sd0, 32'd65536);
    send_item(-32'sd524288, 32'sd0, 32'd65536);
    send_item(32'sd524287, 32'sd0, 32'd65536);
    send_item(32'sd1, 32'sd0, 32'd1);
    send_item(32'sd1, 32'sd0, 32'hFFFFFFFF);
    send_item(-32'sd1, 32'sd0, 32'd4);
    drain();

    for (int n = 0; n < 380; n++) begin
      if (n == 100) rx_hold = 400;
      send_random();
    end
    drain();
    tx_idle_pct = 65;
    rx_idle_pct = 19;
    for (int n = 0; n < 380; n++) send_random();
    drain();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    for (int n = 0; n < 380; n++) send_random();
    drain();
    repeat (200) @(posedge clk);
    if (sb.mismatches == 0 && sb.outstanding() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule
